/* hw/rtl/bdct_pkg.sv */
package bdct_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREP   = 2'd1,
    PH_SETTLE = 2'd2,
    PH_LOAD   = 2'd3
  } phase_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_END_V   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_V  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_V = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_V = 3'd5;

  localparam logic [15:0] RST_END_V   = 16'd20000;
  localparam logic [19:0] RST_MIN_CAP = 20'd0;
  localparam logic [19:0] RST_SETTLE  = 20'd30000;
  localparam logic [15:0] RST_FULL_V  = 16'd28800;
  localparam logic [15:0] RST_EMPTY_V = 16'd21000;
  localparam logic [15:0] RST_FLOOR_V = 16'd20000;

  localparam logic [15:0] MS_PER_S      = 16'd1000;
  localparam logic [31:0] SEC_PER_HOUR  = 32'd3600;
  // ceil(2^38 / 1000): whole seconds are the top bits of the 61-bit product
  localparam logic [28:0] SEC_RECIP     = 29'd274877907;
  localparam int          ITER_W        = 7;
  localparam logic [ITER_W-1:0] EST_ITERS  = 7'd64;

  localparam logic [47:0] CHARGE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] ENERGY_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic   latch_in;
    logic   clear;
    logic   capture;
    logic   div_time;
    logic   mul_q;
    logic   acc_q;
    logic   acc_e;
    logic   mul_n;
    logic   div_est;
    logic   est_write;
    logic   est_invalid;
    logic   check_end;
    logic   out_load;
    phase_t phase;
    logic   apply_load;
    logic   done;
  } dp_cmd_t;

  typedef struct packed {
    logic start_cmd;
    logic ready;
    logic settle_over;
    logic drop_pos;
    logic volt_low;
    logic div_busy;
  } dp_stat_t;

endpackage

/* hw/rtl/battery_discharge_capacity_test_core.sv */
// Battery discharge capacity test core: counts charge (mA*s) and energy (uJ) drawn from a
// battery under load and estimates its full capacity, one result beat per input beat. Start,
// prepare, settle and idle polls, and loading polls without a fresh reading, go straight to the
// output register. A loading poll with a fresh reading also turns elapsed milliseconds into
// whole seconds by a reciprocal multiplication and accumulates charge and energy; when the
// voltage has dropped below its captured start value, a radix-2 divider, one quotient bit per
// cycle, runs 64 steps to divide the scaled charge by the drop. The next input beat is taken
// as soon as the previous result sits in the output register, even while it is stalled.
module battery_discharge_capacity_test_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bdct_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bdct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [31:0]                      in_now_ms,
  input  logic                             in_reading_ready,
  input  logic [15:0]                      in_current_ma,
  input  logic [15:0]                      in_voltage_mv,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_phase_now,
  output logic                             out_apply_load,
  output logic [47:0]                      out_charge_mas,
  output logic [62:0]                      out_energy_uj,
  output logic [47:0]                      out_estimate_mas,
  output logic                             out_estimate_valid,
  output logic                             out_test_done,
  output logic                             out_test_failed
);
  import bdct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  bdct_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .in_cmd             (in_cmd),
    .in_now_ms          (in_now_ms),
    .in_reading_ready   (in_reading_ready),
    .in_current_ma      (in_current_ma),
    .in_voltage_mv      (in_voltage_mv),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_phase_now      (out_phase_now),
    .out_apply_load     (out_apply_load),
    .out_charge_mas     (out_charge_mas),
    .out_energy_uj      (out_energy_uj),
    .out_estimate_mas   (out_estimate_mas),
    .out_estimate_valid (out_estimate_valid),
    .out_test_done      (out_test_done),
    .out_test_failed    (out_test_failed)
  );

endmodule

/* hw/rtl/bdct_div.sv */
module bdct_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  logic [63:0]                    dividend_i,
  input  logic [15:0]                    divisor_i,
  input  logic [bdct_pkg::ITER_W-1:0]    iters_i,
  output logic                           busy_o,
  output logic [63:0]                    quot_o
);
  import bdct_pkg::*;

  logic [63:0]       quo_r;
  logic [15:0]       rem_r;
  logic [15:0]       dvs_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic [16:0]       trial;
  logic              fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= iters_i;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[62:0], fits};
      rem_r <= fits ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
    end
  end

  assign busy_o = busy_r;
  assign quot_o = quo_r;

endmodule

/* hw/rtl/bdct_dp.sv */
module bdct_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bdct_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bdct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_cmd,
  input  logic [31:0]                      in_now_ms,
  input  logic                             in_reading_ready,
  input  logic [15:0]                      in_current_ma,
  input  logic [15:0]                      in_voltage_mv,
  input  bdct_pkg::dp_cmd_t                cmd_i,
  output bdct_pkg::dp_stat_t               stat_o,
  output logic [1:0]                       out_phase_now,
  output logic                             out_apply_load,
  output logic [47:0]                      out_charge_mas,
  output logic [62:0]                      out_energy_uj,
  output logic [47:0]                      out_estimate_mas,
  output logic                             out_estimate_valid,
  output logic                             out_test_done,
  output logic                             out_test_failed
);
  import bdct_pkg::*;

  localparam int SW = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

  logic [15:0] end_v_r, full_v_r, empty_v_r, floor_v_r;
  logic [19:0] min_cap_r, settle_r;

  logic          cmd_r, ready_r;
  logic [31:0]   now_r;
  logic [SW-1:0] cur_r, volt_r;

  logic [31:0] start_time_r, last_time_r;
  logic [15:0] init_v_r;
  logic [47:0] charge_r, est_r;
  logic [62:0] energy_r;
  logic        est_ok_r, failed_r;

  logic [31:0] gap_r;
  logic [22:0] secs_r;
  logic [38:0] dq_r;
  logic [54:0] de_r;
  logic [39:0] plo_r;
  logic [63:0] num_r;

  logic [1:0]  o_phase_r;
  logic        o_load_r, o_done_r, o_ok_r, o_fail_r;
  logic [47:0] o_charge_r, o_est_r;
  logic [62:0] o_energy_r;

  logic [15:0] volt16, drop, span;
  logic [31:0] elapsed, min_thr;
  logic [60:0] recip_prod;
  logic [38:0] dq_prod;
  logic [54:0] de_prod;
  logic [48:0] charge_sum;
  logic [63:0] energy_sum;
  logic [39:0] plo_prod, phi_prod;
  logic [63:0] num_sum;
  logic        div_busy;
  logic [63:0] quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_v_r   <= RST_END_V;
      min_cap_r <= RST_MIN_CAP;
      settle_r  <= RST_SETTLE;
      full_v_r  <= RST_FULL_V;
      empty_v_r <= RST_EMPTY_V;
      floor_v_r <= RST_FLOOR_V;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_END_V:   end_v_r   <= cfg_wdata[15:0];
        REG_MIN_CAP: min_cap_r <= cfg_wdata;
        REG_SETTLE:  settle_r  <= cfg_wdata;
        REG_FULL_V:  full_v_r  <= cfg_wdata[15:0];
        REG_EMPTY_V: empty_v_r <= cfg_wdata[15:0];
        REG_FLOOR_V: floor_v_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch_in) begin
      cmd_r   <= in_cmd;
      now_r   <= in_now_ms;
      ready_r <= in_reading_ready;
      cur_r   <= in_current_ma[SW-1:0];
      volt_r  <= in_voltage_mv[SW-1:0];
    end
  end

  assign volt16     = 16'(volt_r);
  assign drop       = init_v_r - volt16;
  assign span       = (full_v_r > empty_v_r) ? full_v_r - empty_v_r : 16'd0;
  assign elapsed    = now_r - start_time_r;
  assign min_thr    = 32'(min_cap_r) * SEC_PER_HOUR;
  assign recip_prod = 61'(gap_r) * 61'(SEC_RECIP);
  assign dq_prod    = 39'(cur_r) * 39'(secs_r);
  assign de_prod    = 55'(dq_r) * 55'(volt_r);
  assign charge_sum = 49'(charge_r) + 49'(dq_r);
  assign energy_sum = 64'(energy_r) + 64'(de_r);
  assign plo_prod   = 40'(charge_r[23:0]) * 40'(span);
  assign phi_prod   = 40'(charge_r[47:24]) * 40'(span);
  assign num_sum    = {phi_prod, 24'd0} + 64'(plo_r);

  bdct_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_est),
    .dividend_i (num_r),
    .divisor_i  (drop),
    .iters_i    (EST_ITERS),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= '0;
      last_time_r  <= '0;
      init_v_r     <= '0;
      charge_r     <= '0;
      energy_r     <= '0;
      est_r        <= '0;
      est_ok_r     <= 1'b0;
      failed_r     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        start_time_r <= now_r;
        charge_r     <= '0;
        energy_r     <= '0;
        est_r        <= '0;
        est_ok_r     <= 1'b0;
        failed_r     <= 1'b0;
      end
      if (cmd_i.capture) begin
        init_v_r    <= volt16;
        last_time_r <= now_r;
      end
      if (cmd_i.div_time) begin
        last_time_r <= now_r;
      end
      if (cmd_i.acc_q) begin
        charge_r <= (charge_sum >= 49'(CHARGE_MAX)) ? CHARGE_MAX : charge_sum[47:0];
      end
      if (cmd_i.acc_e) begin
        energy_r <= (energy_sum >= 64'(ENERGY_MAX)) ? ENERGY_MAX : energy_sum[62:0];
      end
      if (cmd_i.est_write) begin
        est_r    <= (quot[63:48] != 16'd0) ? CHARGE_MAX : quot[47:0];
        est_ok_r <= 1'b1;
      end
      if (cmd_i.est_invalid) begin
        est_ok_r <= 1'b0;
      end
      if (cmd_i.check_end && (charge_r < 48'(min_thr))) begin
        failed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.div_time) begin
      gap_r <= now_r - last_time_r;
    end
    secs_r <= recip_prod[60:38];
    if (cmd_i.mul_q) begin
      dq_r <= dq_prod;
    end
    if (cmd_i.acc_q) begin
      de_r <= de_prod;
    end
    if (cmd_i.acc_e) begin
      plo_r <= plo_prod;
    end
    if (cmd_i.mul_n) begin
      num_r <= num_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      o_phase_r  <= cmd_i.phase;
      o_load_r   <= cmd_i.apply_load;
      o_done_r   <= cmd_i.done;
      o_charge_r <= charge_r;
      o_energy_r <= energy_r;
      o_est_r    <= est_r;
      o_ok_r     <= est_ok_r;
      o_fail_r   <= failed_r;
    end
  end

  assign stat_o.start_cmd   = (cmd_r == CMD_START);
  assign stat_o.ready       = ready_r;
  assign stat_o.settle_over = elapsed > 32'(settle_r);
  assign stat_o.drop_pos    = init_v_r > volt16;
  assign stat_o.volt_low    = (volt16 < end_v_r) || (volt16 < floor_v_r);
  assign stat_o.div_busy    = div_busy;

  assign out_phase_now      = o_phase_r;
  assign out_apply_load     = o_load_r;
  assign out_charge_mas     = o_charge_r;
  assign out_energy_uj      = o_energy_r;
  assign out_estimate_mas   = o_est_r;
  assign out_estimate_valid = o_ok_r;
  assign out_test_done      = o_done_r;
  assign out_test_failed    = o_fail_r;

endmodule

/* hw/rtl/bdct_ctrl.sv */
module bdct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output bdct_pkg::dp_cmd_t   cmd_o,
  input  bdct_pkg::dp_stat_t  stat_i
);
  import bdct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SECS,
    S_MUL_Q,
    S_ACC_Q,
    S_ACC_E,
    S_MUL_N,
    S_CHK,
    S_DIV_E,
    S_END,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   load_r, load_nxt;
  logic   done_r, done_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    load_nxt      = load_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd_o            = '0;
    cmd_o.phase      = phase_r;
    cmd_o.apply_load = load_r;
    cmd_o.done       = done_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.latch_in = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        load_nxt  = 1'b0;
        done_nxt  = 1'b0;
        state_nxt = S_OUT;
        priority if (stat_i.start_cmd) begin
          cmd_o.clear = 1'b1;
          phase_nxt   = PH_PREP;
        end else if (phase_r == PH_PREP) begin
          load_nxt  = 1'b1;
          phase_nxt = PH_SETTLE;
        end else if (phase_r == PH_SETTLE) begin
          if (stat_i.settle_over) begin
            cmd_o.capture = 1'b1;
            phase_nxt     = PH_LOAD;
          end
        end else if (phase_r == PH_LOAD && stat_i.ready) begin
          cmd_o.div_time = 1'b1;
          state_nxt      = S_SECS;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SECS: begin
        state_nxt = S_MUL_Q;
      end
      S_MUL_Q: begin
        cmd_o.mul_q = 1'b1;
        state_nxt   = S_ACC_Q;
      end
      S_ACC_Q: begin
        cmd_o.acc_q = 1'b1;
        state_nxt   = S_ACC_E;
      end
      S_ACC_E: begin
        cmd_o.acc_e = 1'b1;
        state_nxt   = S_MUL_N;
      end
      S_MUL_N: begin
        cmd_o.mul_n = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (stat_i.drop_pos) begin
          cmd_o.div_est = 1'b1;
          state_nxt     = S_DIV_E;
        end else begin
          cmd_o.est_invalid = 1'b1;
          state_nxt         = S_END;
        end
      end
      S_DIV_E: begin
        if (!stat_i.div_busy) begin
          cmd_o.est_write = 1'b1;
          state_nxt       = S_END;
        end
      end
      S_END: begin
        if (stat_i.volt_low) begin
          cmd_o.check_end = 1'b1;
          phase_nxt       = PH_IDLE;
          done_nxt        = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      load_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      load_r      <= load_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
